>>> rtl/core/utt_pkg.sv
// utt_pkg: shared types and constants for the utf-8 to utf-16 transcoder
// used by utt_decode and utf8_to_utf16_transcoder; no dependencies
package utt_pkg;

  // decoder state codes; codes 8..15 are never entered and decode as begin
  typedef enum logic [3:0] {
    ST_BEGIN    = 4'd0,
    ST_NEED1    = 4'd1,
    ST_NEED2    = 4'd2,
    ST_NEED3    = 4'd3,
    ST_AFTER_E0 = 4'd4,
    ST_AFTER_ED = 4'd5,
    ST_AFTER_F0 = 4'd6,
    ST_AFTER_F4 = 4'd7
  } dec_state_t;

  localparam int unsigned ACC_W     = 21;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0]      REPL_CHAR  = 16'hFFFD;
  localparam logic [15:0]      HI_SURR    = 16'hD800;
  localparam logic [15:0]      LO_SURR    = 16'hDC00;
  localparam logic [ACC_W-1:0] SUPP_BASE  = 21'h010000;
  localparam logic [ACC_W-1:0] SCALAR_MAX = 21'h10FFFF;
  localparam logic [ACC_W-1:0] SURR_FIRST = 21'h00D800;
  localparam logic [ACC_W-1:0] SURR_LAST  = 21'h00DFFF;

  // one utf-16 unit before the per-transaction flags are attached
  typedef struct packed {
    logic [15:0] code;
    logic        repl;
  } unit_t;

  // everything the decoder works out for one byte
  typedef struct packed {
    logic [1:0]       nres;
    unit_t            unit0;
    unit_t            unit1;
    dec_state_t       state;
    logic [ACC_W-1:0] acc;
  } dec_out_t;

  // one entry of the result queue
  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_last;
    logic        final_unit;
  } res_t;

endpackage

>>> rtl/core/utt_decode.sv
// utt_decode: validating utf-8 automaton step for one byte, combinational
// depends on utt_pkg
module utt_decode (
  input  utt_pkg::dec_state_t       state,
  input  logic [utt_pkg::ACC_W-1:0] acc,
  input  logic [7:0]                byte_value,
  input  logic                      string_end,
  output utt_pkg::dec_out_t         dec
);

  logic                      cont;
  logic                      fit;
  logic                      sub_range;
  logic                      do_start;
  logic [1:0]                n;
  utt_pkg::unit_t            units [2];
  utt_pkg::dec_state_t       fit_state;
  utt_pkg::dec_state_t       ns;
  logic [utt_pkg::ACC_W-1:0] nacc;
  logic [utt_pkg::ACC_W-1:0] v;

  always_comb begin
    cont      = (byte_value[7:6] == 2'b10);
    fit       = 1'b0;
    fit_state = utt_pkg::ST_BEGIN;
    sub_range = 1'b0;
    do_start  = 1'b0;
    n         = 2'd0;
    units[0]  = '{code: utt_pkg::REPL_CHAR, repl: 1'b1};
    units[1]  = '{code: utt_pkg::REPL_CHAR, repl: 1'b1};
    ns        = state;
    nacc      = acc;
    v         = nacc - utt_pkg::SUPP_BASE;

    unique case (state)
      utt_pkg::ST_NEED1: begin
        fit = cont;  fit_state = utt_pkg::ST_BEGIN;
      end
      utt_pkg::ST_NEED2: begin
        fit = cont;  fit_state = utt_pkg::ST_NEED1;
      end
      utt_pkg::ST_NEED3: begin
        fit = cont;  fit_state = utt_pkg::ST_NEED2;
      end
      utt_pkg::ST_AFTER_E0: begin
        fit = (byte_value >= 8'hA0) && (byte_value <= 8'hBF);
        fit_state = utt_pkg::ST_NEED1;  sub_range = 1'b1;
      end
      utt_pkg::ST_AFTER_ED: begin
        fit = (byte_value >= 8'h80) && (byte_value <= 8'h9F);
        fit_state = utt_pkg::ST_NEED1;  sub_range = 1'b1;
      end
      utt_pkg::ST_AFTER_F0: begin
        fit = (byte_value >= 8'h90) && (byte_value <= 8'hBF);
        fit_state = utt_pkg::ST_NEED2;  sub_range = 1'b1;
      end
      utt_pkg::ST_AFTER_F4: begin
        fit = (byte_value >= 8'h80) && (byte_value <= 8'h8F);
        fit_state = utt_pkg::ST_NEED2;  sub_range = 1'b1;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (!do_start) begin
      if (fit) begin
        nacc = {acc[utt_pkg::ACC_W-7:0], byte_value[5:0]};
        ns   = fit_state;
        v    = nacc - utt_pkg::SUPP_BASE;
        if (fit_state == utt_pkg::ST_BEGIN) begin
          if ((nacc >= utt_pkg::SUPP_BASE) && (nacc <= utt_pkg::SCALAR_MAX)) begin
            units[0] = '{code: utt_pkg::HI_SURR + {6'd0, v[19:10]}, repl: 1'b0};
            units[1] = '{code: utt_pkg::LO_SURR + {6'd0, v[9:0]}, repl: 1'b0};
            n = 2'd2;
          end else if ((nacc < utt_pkg::SUPP_BASE) &&
                       ((nacc < utt_pkg::SURR_FIRST) || (nacc > utt_pkg::SURR_LAST))) begin
            units[0] = '{code: nacc[15:0], repl: 1'b0};
            n = 2'd1;
          end else begin
            n = 2'd1;
          end
        end
      end else begin
        // broken sequence: one replacement, then maybe decode the byte afresh
        n        = 2'd1;
        ns       = utt_pkg::ST_BEGIN;
        do_start = !(sub_range && cont);
      end
    end

    if (do_start) begin
      if (byte_value <= 8'h7F) begin
        units[n[0]] = '{code: {8'd0, byte_value}, repl: 1'b0};
        n  = n + 2'd1;
        ns = utt_pkg::ST_BEGIN;
      end else if ((byte_value >= 8'hC2) && (byte_value <= 8'hDF)) begin
        ns   = utt_pkg::ST_NEED1;
        nacc = {16'd0, byte_value[4:0]};
      end else if ((byte_value >= 8'hE0) && (byte_value <= 8'hEF)) begin
        ns   = (byte_value == 8'hE0) ? utt_pkg::ST_AFTER_E0 :
               (byte_value == 8'hED) ? utt_pkg::ST_AFTER_ED : utt_pkg::ST_NEED2;
        nacc = {17'd0, byte_value[3:0]};
      end else if ((byte_value >= 8'hF0) && (byte_value <= 8'hF4)) begin
        ns   = (byte_value == 8'hF0) ? utt_pkg::ST_AFTER_F0 :
               (byte_value == 8'hF4) ? utt_pkg::ST_AFTER_F4 : utt_pkg::ST_NEED3;
        nacc = {18'd0, byte_value[2:0]};
      end else begin
        units[n[0]] = '{code: utt_pkg::REPL_CHAR, repl: 1'b1};
        n  = n + 2'd1;
        ns = utt_pkg::ST_BEGIN;
      end
    end

    // truncated sequence at the end of the string
    if (string_end) begin
      if (ns != utt_pkg::ST_BEGIN) begin
        units[n[0]] = '{code: utt_pkg::REPL_CHAR, repl: 1'b1};
        n = n + 2'd1;
      end
      ns   = utt_pkg::ST_BEGIN;
      nacc = '0;
    end

    dec.nres  = n;
    dec.unit0 = units[0];
    dec.unit1 = units[1];
    dec.state = ns;
    dec.acc   = nacc;
  end

endmodule

>>> rtl/core/utf8_to_utf16_transcoder.sv
// utf8_to_utf16_transcoder: top level, input register, decoder and result queue
// depends on utt_pkg and utt_decode
//
// Streams UTF-8 bytes in, one per transaction, and returns UTF-16 code units,
// one per transaction. A byte is taken every cycle unless in_stall is high;
// it sits in the input register while the decoder works out its units, which
// are then written, zero, one or two at a time, into a four-entry result
// queue. The output drains one unit per cycle while out_stall is low, so a
// byte that yields two units (a surrogate pair, or a replacement followed by
// the byte decoded afresh) fills two queue entries, and the input stalls only
// when the queue has no room for the byte held in the input register.
// Overlong forms, encoded surrogates and values above 0x10FFFF are
// rejected; each ill-formed or truncated sequence gives one U+FFFD with
// replaced set. run_last marks the last unit caused by a byte and final_unit
// the last unit of a string.
module utf8_to_utf16_transcoder (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_string_end,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_replaced,
  output logic        out_run_last,
  output logic        out_final_unit
);

  // input register
  logic                      in_valid_r, in_valid_nxt;
  logic [7:0]                byte_r;
  logic                      end_r;

  // decoder state
  utt_pkg::dec_state_t       state_r;
  logic [utt_pkg::ACC_W-1:0] acc_r;

  // result queue
  utt_pkg::res_t             queue_r [utt_pkg::QUEUE_DEPTH];
  logic [1:0]                wr_ptr_r, wr_ptr_nxt;
  logic [1:0]                rd_ptr_r, rd_ptr_nxt;
  logic [2:0]                count_r, count_nxt;

  utt_pkg::dec_out_t         dec;
  logic                      advance;
  logic                      in_take;
  logic                      out_take;
  logic [3:0]                fill_after;
  utt_pkg::res_t             res0, res1;

  utt_decode u_decode (
    .state      (state_r),
    .acc        (acc_r),
    .byte_value (byte_r),
    .string_end (end_r),
    .dec        (dec)
  );

  // the held byte moves on once the queue has room for all its units
  assign fill_after = {1'b0, count_r} + {2'd0, dec.nres};
  assign advance    = in_valid_r && (fill_after <= 4'd4);
  assign in_stall   = in_valid_r && !advance;
  assign in_take    = in_valid && !in_stall;

  assign out_valid  = (count_r != 3'd0);
  assign out_take   = out_valid && !out_stall;

  // per-transaction flags go onto the last unit of the byte
  always_comb begin
    res0.code_unit  = dec.unit0.code;
    res0.replaced   = dec.unit0.repl;
    res0.run_last   = (dec.nres == 2'd1);
    res0.final_unit = (dec.nres == 2'd1) && end_r;
    res1.code_unit  = dec.unit1.code;
    res1.replaced   = dec.unit1.repl;
    res1.run_last   = 1'b1;
    res1.final_unit = end_r;
  end

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    wr_ptr_nxt = advance ? (wr_ptr_r + dec.nres) : wr_ptr_r;
    rd_ptr_nxt = out_take ? (rd_ptr_r + 2'd1) : rd_ptr_r;
    count_nxt  = count_r + (advance ? {1'b0, dec.nres} : 3'd0)
                         - (out_take ? 3'd1 : 3'd0);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= utt_pkg::ST_BEGIN;
      acc_r      <= '0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      count_r    <= count_nxt;
      if (advance) begin
        state_r <= dec.state;
        acc_r   <= dec.acc;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte_value;
      end_r  <= in_string_end;
    end
    if (advance && (dec.nres != 2'd0)) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (advance && (dec.nres == 2'd2)) begin
      queue_r[wr_ptr_r + 2'd1] <= res1;
    end
  end

  assign out_code_unit  = queue_r[rd_ptr_r].code_unit;
  assign out_replaced   = queue_r[rd_ptr_r].replaced;
  assign out_run_last   = queue_r[rd_ptr_r].run_last;
  assign out_final_unit = queue_r[rd_ptr_r].final_unit;

`ifndef SYNTHESIS
  // queue never overfills
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("result queue overfilled");

  // a string-end byte always yields at least one unit
  a_end_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && end_r) |-> (dec.nres != 2'd0))
    else $error("string end produced no unit");

  // decoder returns to begin after the string end
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && end_r) |=> (state_r == utt_pkg::ST_BEGIN) && (acc_r == '0))
    else $error("state not cleared after string end");

  // draining the last unit with nothing new empties the queue
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && (count_r == 3'd1) && !advance) |=> !out_valid)
    else $error("queue count out of step");
`endif

endmodule
